>>> rtl/core/s2c_pkg.sv
// Shared constants of the spherical-to-Cartesian vector core.
// Holds default word and fraction widths and the divider lane layout.
// Depends on nothing.
package s2c_pkg;

	localparam int unsigned WORD_BITS_DEF = 32;
	localparam int unsigned FRAC_BITS_DEF = 16;

	localparam int unsigned DIV_LANES = 4;
	localparam int unsigned LANE_SIN_PHI = 0;
	localparam int unsigned LANE_COS_PHI = 1;
	localparam int unsigned LANE_SIN_TH = 2;
	localparam int unsigned LANE_COS_TH = 3;

endpackage

>>> rtl/core/s2c_isqrt.sv
// Pipelined floor square roots of two radicands, one result bit per stage.
// Carries a sideband vector alongside; uses s2c_pkg for default widths.
module s2c_isqrt #(
	parameter int unsigned WORD_BITS = s2c_pkg::WORD_BITS_DEF,
	parameter int unsigned SIDE_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     src_vld,
	input  logic [2*WORD_BITS-1:0]   rad_a,
	input  logic [2*WORD_BITS-1:0]   rad_b,
	input  logic [SIDE_BITS-1:0]     side_in,
	output logic                     dst_vld,
	output logic [WORD_BITS-1:0]     root_a,
	output logic [WORD_BITS-1:0]     root_b,
	output logic [SIDE_BITS-1:0]     side_out
);

	localparam int unsigned W = WORD_BITS;
	localparam int unsigned REMW = W + 3;

	function automatic logic [REMW+W-1:0] sq_step(input logic [REMW-1:0] rem,
		input logic [1:0] pair, input logic [W-1:0] root);
		logic [REMW-1:0] cur;
		logic [REMW-1:0] trial;
		cur = {rem[REMW-3:0], pair};
		trial = {1'b0, root, 2'b01};
		if (cur >= trial) begin
			return {cur - trial, root[W-2:0], 1'b1};
		end
		return {cur, root[W-2:0], 1'b0};
	endfunction

	logic [W:0]                vld_s;
	logic [W:0][2*W-1:0]       rada_s;
	logic [W:0][2*W-1:0]       radb_s;
	logic [W:0][REMW-1:0]      rema_s;
	logic [W:0][REMW-1:0]      remb_s;
	logic [W:0][W-1:0]         roota_s;
	logic [W:0][W-1:0]         rootb_s;
	logic [W:0][SIDE_BITS-1:0] side_s;

	assign vld_s[0] = src_vld;
	assign rada_s[0] = rad_a;
	assign radb_s[0] = rad_b;
	assign rema_s[0] = '0;
	assign remb_s[0] = '0;
	assign roota_s[0] = '0;
	assign rootb_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < W; i++) begin : g_step
		logic [REMW+W-1:0] nxt_a;
		logic [REMW+W-1:0] nxt_b;

		assign nxt_a = sq_step(rema_s[i], rada_s[i][2*W-1 -: 2], roota_s[i]);
		assign nxt_b = sq_step(remb_s[i], radb_s[i][2*W-1 -: 2], rootb_s[i]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rada_s[i+1] <= {rada_s[i][2*W-3:0], 2'b00};
				radb_s[i+1] <= {radb_s[i][2*W-3:0], 2'b00};
				rema_s[i+1] <= nxt_a[REMW+W-1:W];
				remb_s[i+1] <= nxt_b[REMW+W-1:W];
				roota_s[i+1] <= nxt_a[W-1:0];
				rootb_s[i+1] <= nxt_b[W-1:0];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign dst_vld = vld_s[W];
	assign root_a = roota_s[W];
	assign root_b = rootb_s[W];
	assign side_out = side_s[W];

endmodule

>>> rtl/core/s2c_div.sv
// Pipelined restoring divider forming the rounded sine and cosine ratios.
// Four lanes, one quotient bit per stage; uses s2c_pkg for the lane count.
module s2c_div #(
	parameter int unsigned WORD_BITS = s2c_pkg::WORD_BITS_DEF,
	parameter int unsigned FRAC_BITS = s2c_pkg::FRAC_BITS_DEF,
	parameter int unsigned SIDE_BITS = 8
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         en,
	input  logic                                         src_vld,
	input  logic [s2c_pkg::DIV_LANES-1:0][WORD_BITS-1:0] num,
	input  logic [s2c_pkg::DIV_LANES-1:0][WORD_BITS-1:0] den,
	input  logic [s2c_pkg::DIV_LANES-1:0]                neg,
	input  logic [s2c_pkg::DIV_LANES-1:0]                zero,
	input  logic [SIDE_BITS-1:0]                         side_in,
	output logic                                         dst_vld,
	output logic [s2c_pkg::DIV_LANES-1:0][FRAC_BITS+1:0] trig,
	output logic [SIDE_BITS-1:0]                         side_out
);

	import s2c_pkg::*;

	localparam int unsigned W = WORD_BITS;
	localparam int unsigned F = FRAC_BITS;
	localparam int unsigned L = DIV_LANES;
	localparam int unsigned NW = W + F + 1;
	localparam int unsigned T = F + 2;

	logic [F+1:0]                   vld_s;
	logic [F+1:0][L-1:0][NW-1:0]    rem_s;
	logic [F+1:0][L-1:0][W-1:0]     den_s;
	logic [F+1:0][L-1:0][F:0]       quo_s;
	logic [F+1:0][L-1:0]            neg_s;
	logic [F+1:0][L-1:0]            zero_s;
	logic [F+1:0][SIDE_BITS-1:0]    side_s;

	assign vld_s[0] = src_vld;
	assign neg_s[0] = neg;
	assign zero_s[0] = zero;
	assign side_s[0] = side_in;
	for (genvar l = 0; l < L; l++) begin : g_init
		assign rem_s[0][l] = (NW'(num[l]) << F) + NW'(den[l] >> 1);
		assign den_s[0][l] = den[l];
		assign quo_s[0][l] = '0;
	end

	for (genvar j = 0; j <= F; j++) begin : g_step
		logic [L-1:0][NW-1:0] dsh;
		logic [L-1:0]         ge;

		for (genvar l = 0; l < L; l++) begin : g_lane
			assign dsh[l] = NW'(den_s[j][l]) << (F - j);
			assign ge[l] = rem_s[j][l] >= dsh[l];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < L; l++) begin
					rem_s[j+1][l] <= ge[l] ? rem_s[j][l] - dsh[l] : rem_s[j][l];
					quo_s[j+1][l] <= {quo_s[j][l][F-1:0], ge[l]};
					den_s[j+1][l] <= den_s[j][l];
				end
				neg_s[j+1] <= neg_s[j];
				zero_s[j+1] <= zero_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	for (genvar l = 0; l < L; l++) begin : g_out
		logic [T-1:0] qx;

		assign qx = T'(quo_s[F+1][l]);
		assign trig[l] = zero_s[F+1][l] ? '0 : (neg_s[F+1][l] ? -qx : qx);
	end

	assign dst_vld = vld_s[F+1];
	assign side_out = side_s[F+1];

`ifndef SYNTHESIS
	a_ratio_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[F+1] |-> ((zero_s[F+1][LANE_SIN_PHI]
				|| quo_s[F+1][LANE_SIN_PHI] <= (F+1)'(1 << F))
			&& (zero_s[F+1][LANE_COS_TH]
				|| quo_s[F+1][LANE_COS_TH] <= (F+1)'(1 << F))))
		else $error("sine or cosine magnitude above one");
`endif

endmodule

>>> rtl/core/s2c_rotate.sv
// Rotation of the spherical components into Cartesian ones, five stages.
// Multiplies, rounds, sums and saturates; uses s2c_pkg for default widths.
module s2c_rotate #(
	parameter int unsigned WORD_BITS = s2c_pkg::WORD_BITS_DEF,
	parameter int unsigned FRAC_BITS = s2c_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        src_vld,
	input  logic signed [WORD_BITS-1:0] vr,
	input  logic signed [WORD_BITS-1:0] vt,
	input  logic signed [WORD_BITS-1:0] vp,
	input  logic signed [FRAC_BITS+1:0] sp,
	input  logic signed [FRAC_BITS+1:0] cp,
	input  logic signed [FRAC_BITS+1:0] st,
	input  logic signed [FRAC_BITS+1:0] ct,
	input  logic [WORD_BITS-1:0]        psi_in,
	output logic                        dst_vld,
	output logic signed [WORD_BITS-1:0] cx,
	output logic signed [WORD_BITS-1:0] cy,
	output logic signed [WORD_BITS-1:0] cz,
	output logic [WORD_BITS-1:0]        psi_out
);

	localparam int unsigned W = WORD_BITS;
	localparam int unsigned F = FRAC_BITS;
	localparam int unsigned T = F + 2;
	localparam int unsigned TW = W + 2;
	localparam int unsigned PW1 = W + F + 1;
	localparam int unsigned PW2 = W + F + 2;
	localparam int unsigned SXW = TW + 2;
	localparam logic signed [SXW-1:0] WMAX = {{(SXW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [SXW-1:0] WMIN = ~WMAX;

	function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
		return v[W-1] ? W'(-v) : W'(v);
	endfunction

	function automatic logic [F:0] mag_t(input logic signed [T-1:0] v);
		logic [T-1:0] u;
		u = v[T-1] ? -v : v;
		return u[F:0];
	endfunction

	function automatic logic [W:0] mag_tw(input logic signed [TW-1:0] v);
		logic [TW-1:0] u;
		u = v[TW-1] ? -v : v;
		return u[W:0];
	endfunction

	function automatic logic signed [TW-1:0] rnd1(input logic [PW1-1:0] p, input logic n);
		logic [PW1:0] s;
		logic [TW-1:0] m;
		s = {1'b0, p} + (PW1+1)'(1 << (F - 1));
		m = TW'(s >> F);
		return n ? -m : m;
	endfunction

	function automatic logic signed [TW-1:0] rnd2(input logic [PW2-1:0] p, input logic n);
		logic [PW2:0] s;
		logic [TW-1:0] m;
		s = {1'b0, p} + (PW2+1)'(1 << (F - 1));
		m = TW'(s >> F);
		return n ? -m : m;
	endfunction

	function automatic logic signed [W-1:0] sat_w(input logic signed [SXW-1:0] v);
		if (v > WMAX) begin
			return WMAX[W-1:0];
		end
		if (v < WMIN) begin
			return WMIN[W-1:0];
		end
		return v[W-1:0];
	endfunction

	logic [5:1] vld_s;

	logic [PW1-1:0] pa_s1, pb_s1, pc_s1, pd_s1, pe_s1, pf_s1;
	logic           na_s1, nb_s1, nc_s1, nd_s1, ne_s1, nf_s1;
	logic signed [T-1:0] sp_s1, cp_s1, sp_s2, cp_s2;
	logic [W-1:0]   psi_s1, psi_s2, psi_s3, psi_s4, psi_s5;

	logic signed [TW-1:0] ta_s2, tb_s2, tc_s2, td_s2, te_s2, tf_s2;

	logic [PW2-1:0] pac_s3, pbc_s3, pas_s3, pbs_s3;
	logic           nac_s3, nbc_s3, nas_s3, nbs_s3;
	logic signed [TW-1:0] tc_s3, td_s3, te_s3, tf_s3;

	logic signed [TW-1:0] tac_s4, tbc_s4, tas_s4, tbs_s4;
	logic signed [TW-1:0] tc_s4, td_s4, te_s4, tf_s4;

	logic signed [W-1:0] cx_s5, cy_s5, cz_s5;
	logic signed [SXW-1:0] sum_x, sum_y, sum_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[4:1], src_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1 <= PW1'(mag_w(vr)) * PW1'(mag_t(st));
			pb_s1 <= PW1'(mag_w(vt)) * PW1'(mag_t(ct));
			pc_s1 <= PW1'(mag_w(vp)) * PW1'(mag_t(sp));
			pd_s1 <= PW1'(mag_w(vp)) * PW1'(mag_t(cp));
			pe_s1 <= PW1'(mag_w(vr)) * PW1'(mag_t(ct));
			pf_s1 <= PW1'(mag_w(vt)) * PW1'(mag_t(st));
			na_s1 <= vr[W-1] ^ st[T-1];
			nb_s1 <= vt[W-1] ^ ct[T-1];
			nc_s1 <= vp[W-1] ^ sp[T-1];
			nd_s1 <= vp[W-1] ^ cp[T-1];
			ne_s1 <= vr[W-1] ^ ct[T-1];
			nf_s1 <= vt[W-1] ^ st[T-1];
			sp_s1 <= sp;
			cp_s1 <= cp;
			psi_s1 <= psi_in;

			ta_s2 <= rnd1(pa_s1, na_s1);
			tb_s2 <= rnd1(pb_s1, nb_s1);
			tc_s2 <= rnd1(pc_s1, nc_s1);
			td_s2 <= rnd1(pd_s1, nd_s1);
			te_s2 <= rnd1(pe_s1, ne_s1);
			tf_s2 <= rnd1(pf_s1, nf_s1);
			sp_s2 <= sp_s1;
			cp_s2 <= cp_s1;
			psi_s2 <= psi_s1;

			pac_s3 <= PW2'(mag_tw(ta_s2)) * PW2'(mag_t(cp_s2));
			pbc_s3 <= PW2'(mag_tw(tb_s2)) * PW2'(mag_t(cp_s2));
			pas_s3 <= PW2'(mag_tw(ta_s2)) * PW2'(mag_t(sp_s2));
			pbs_s3 <= PW2'(mag_tw(tb_s2)) * PW2'(mag_t(sp_s2));
			nac_s3 <= ta_s2[TW-1] ^ cp_s2[T-1];
			nbc_s3 <= tb_s2[TW-1] ^ cp_s2[T-1];
			nas_s3 <= ta_s2[TW-1] ^ sp_s2[T-1];
			nbs_s3 <= tb_s2[TW-1] ^ sp_s2[T-1];
			tc_s3 <= tc_s2;
			td_s3 <= td_s2;
			te_s3 <= te_s2;
			tf_s3 <= tf_s2;
			psi_s3 <= psi_s2;

			tac_s4 <= rnd2(pac_s3, nac_s3);
			tbc_s4 <= rnd2(pbc_s3, nbc_s3);
			tas_s4 <= rnd2(pas_s3, nas_s3);
			tbs_s4 <= rnd2(pbs_s3, nbs_s3);
			tc_s4 <= tc_s3;
			td_s4 <= td_s3;
			te_s4 <= te_s3;
			tf_s4 <= tf_s3;
			psi_s4 <= psi_s3;

			cx_s5 <= sat_w(sum_x);
			cy_s5 <= sat_w(sum_y);
			cz_s5 <= sat_w(sum_z);
			psi_s5 <= psi_s4;
		end
	end

	assign sum_x = SXW'(tac_s4) + SXW'(tbc_s4) - SXW'(tc_s4);
	assign sum_y = SXW'(tas_s4) + SXW'(tbs_s4) + SXW'(td_s4);
	assign sum_z = SXW'(te_s4) - SXW'(tf_s4);

	assign dst_vld = vld_s[5];
	assign cx = cx_s5;
	assign cy = cy_s5;
	assign cz = cz_s5;
	assign psi_out = psi_s5;

endmodule

>>> rtl/core/s2c_norm.sv
// Weighted squared magnitude of the Cartesian vector, five stages.
// Squares, sums, weights the split sum by psi, recombines, rounds and saturates.
// Uses s2c_pkg for default widths.
module s2c_norm #(
	parameter int unsigned WORD_BITS = s2c_pkg::WORD_BITS_DEF,
	parameter int unsigned FRAC_BITS = s2c_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              src_vld,
	input  logic signed [WORD_BITS-1:0]       cx_in,
	input  logic signed [WORD_BITS-1:0]       cy_in,
	input  logic signed [WORD_BITS-1:0]       cz_in,
	input  logic [WORD_BITS-1:0]              psi,
	output logic                              dst_vld,
	output logic signed [WORD_BITS-1:0]       cx_out,
	output logic signed [WORD_BITS-1:0]       cy_out,
	output logic signed [WORD_BITS-1:0]       cz_out,
	output logic [WORD_BITS+FRAC_BITS-1:0]    norm
);

	localparam int unsigned W = WORD_BITS;
	localparam int unsigned F = FRAC_BITS;
	localparam int unsigned NB = W + F;
	localparam int unsigned PW = 3 * W;
	localparam int unsigned CW = ((PW + 1 > NB) ? PW + 1 : NB) + 1;
	localparam logic [CW-1:0] NMASK = CW'({NB{1'b1}});

	function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
		return v[W-1] ? W'(-v) : W'(v);
	endfunction

	logic [5:1] vld_s;
	logic signed [W-1:0] cx_s1, cy_s1, cz_s1, cx_s2, cy_s2, cz_s2;
	logic signed [W-1:0] cx_s3, cy_s3, cz_s3, cx_s4, cy_s4, cz_s4;
	logic signed [W-1:0] cx_s5, cy_s5, cz_s5;
	logic [W-1:0]   psi_s1, psi_s2;
	logic [2*W-1:0] qx_s1, qy_s1, qz_s1;
	logic [2*W-1:0] sum_s2;
	logic [2*W-1:0] ph_s3, pl_s3;
	logic [PW-1:0]  prod_s4;
	logic [NB-1:0]  norm_s5;
	logic [CW-1:0]  rnd;
	logic [CW-1:0]  shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[4:1], src_vld};
		end
	end

	assign rnd = CW'(prod_s4) + (CW'(1) << (2 * F - 1));
	assign shifted = rnd >> (2 * F);

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s1 <= (2*W)'(mag_w(cx_in)) * (2*W)'(mag_w(cx_in));
			qy_s1 <= (2*W)'(mag_w(cy_in)) * (2*W)'(mag_w(cy_in));
			qz_s1 <= (2*W)'(mag_w(cz_in)) * (2*W)'(mag_w(cz_in));
			cx_s1 <= cx_in;
			cy_s1 <= cy_in;
			cz_s1 <= cz_in;
			psi_s1 <= psi;

			sum_s2 <= qx_s1 + qy_s1 + qz_s1;
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
			cz_s2 <= cz_s1;
			psi_s2 <= psi_s1;

			ph_s3 <= (2*W)'(sum_s2[2*W-1:W]) * (2*W)'(psi_s2);
			pl_s3 <= (2*W)'(sum_s2[W-1:0]) * (2*W)'(psi_s2);
			cx_s3 <= cx_s2;
			cy_s3 <= cy_s2;
			cz_s3 <= cz_s2;

			prod_s4 <= {ph_s3, {W{1'b0}}} + PW'(pl_s3);
			cx_s4 <= cx_s3;
			cy_s4 <= cy_s3;
			cz_s4 <= cz_s3;

			norm_s5 <= (shifted > NMASK) ? {NB{1'b1}} : shifted[NB-1:0];
			cx_s5 <= cx_s4;
			cy_s5 <= cy_s4;
			cz_s5 <= cz_s4;
		end
	end

	assign dst_vld = vld_s[5];
	assign cx_out = cx_s5;
	assign cy_out = cy_s5;
	assign cz_out = cz_s5;
	assign norm = norm_s5;

endmodule

>>> rtl/core/spherical_to_cartesian_vector_core.sv
// Throughput: one transaction per cycle; the square root and the divider are
// fully pipelined, one result bit per stage. A stalled result freezes the pipeline.
// Reset clears every valid bit asynchronously; data registers are not reset.
// Top level of the spherical-to-Cartesian vector core.
// Depends on s2c_pkg, s2c_isqrt, s2c_div, s2c_rotate and s2c_norm.
module spherical_to_cartesian_vector_core #(
	parameter int unsigned WORD_BITS = s2c_pkg::WORD_BITS_DEF,
	parameter int unsigned FRAC_BITS = s2c_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic signed [WORD_BITS-1:0]       comp_r,
	input  logic signed [WORD_BITS-1:0]       comp_theta,
	input  logic signed [WORD_BITS-1:0]       comp_phi,
	input  logic [WORD_BITS-1:0]              conformal_factor,
	input  logic signed [WORD_BITS-1:0]       pos_x,
	input  logic signed [WORD_BITS-1:0]       pos_y,
	input  logic signed [WORD_BITS-1:0]       pos_z,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [WORD_BITS-1:0]       cart_x,
	output logic signed [WORD_BITS-1:0]       cart_y,
	output logic signed [WORD_BITS-1:0]       cart_z,
	output logic [WORD_BITS+FRAC_BITS-1:0]    weighted_norm_sq
);

	import s2c_pkg::*;

	localparam int unsigned W = WORD_BITS;
	localparam int unsigned F = FRAC_BITS;
	localparam int unsigned T = F + 2;

	typedef struct packed {
		logic signed [W-1:0] vr;
		logic signed [W-1:0] vt;
		logic signed [W-1:0] vp;
		logic [W-1:0]        psi;
	} comp_t;

	typedef struct packed {
		comp_t        comp;
		logic [W-1:0] ax;
		logic [W-1:0] ay;
		logic [W-1:0] az;
		logic         sx;
		logic         sy;
		logic         sz;
		logic         rc_nz;
		logic         r_nz;
	} geo_side_t;

	logic en;
	logic vld_s1, vld_s2;

	comp_t        comp_s1;
	logic [W-1:0] ax_s1, ay_s1, az_s1;
	logic         sx_s1, sy_s1, sz_s1, rcnz_s1, rnz_s1;
	logic [2*W-1:0] sqx_s1, sqy_s1, sqz_s1;

	geo_side_t      side_s2;
	logic [2*W-1:0] rc2_s2, r2_s2;

	logic [W-1:0] ax_c, ay_c, az_c;

	logic         sq_vld;
	logic [W-1:0] rc_root, r_root;
	geo_side_t    sq_side;

	logic [DIV_LANES-1:0][W-1:0] dv_num, dv_den;
	logic [DIV_LANES-1:0]        dv_neg, dv_zero;
	logic                        dv_vld;
	logic [DIV_LANES-1:0][T-1:0] dv_trig;
	comp_t                       dv_comp;

	logic                rot_vld;
	logic signed [W-1:0] rot_x, rot_y, rot_z;
	logic [W-1:0]        rot_psi;

	assign en = !(result_valid && result_stall);
	assign item_stall = !en;

	assign ax_c = pos_x[W-1] ? W'(-pos_x) : W'(pos_x);
	assign ay_c = pos_y[W-1] ? W'(-pos_y) : W'(pos_y);
	assign az_c = pos_z[W-1] ? W'(-pos_z) : W'(pos_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			comp_s1 <= '{vr: comp_r, vt: comp_theta, vp: comp_phi, psi: conformal_factor};
			ax_s1 <= ax_c;
			ay_s1 <= ay_c;
			az_s1 <= az_c;
			sx_s1 <= pos_x[W-1];
			sy_s1 <= pos_y[W-1];
			sz_s1 <= pos_z[W-1];
			rcnz_s1 <= (pos_x != '0) || (pos_y != '0);
			rnz_s1 <= (pos_x != '0) || (pos_y != '0) || (pos_z != '0);
			sqx_s1 <= (2*W)'(ax_c) * (2*W)'(ax_c);
			sqy_s1 <= (2*W)'(ay_c) * (2*W)'(ay_c);
			sqz_s1 <= (2*W)'(az_c) * (2*W)'(az_c);

			rc2_s2 <= sqx_s1 + sqy_s1;
			r2_s2 <= sqx_s1 + sqy_s1 + sqz_s1;
			side_s2 <= '{comp: comp_s1, ax: ax_s1, ay: ay_s1, az: az_s1,
				sx: sx_s1, sy: sy_s1, sz: sz_s1, rc_nz: rcnz_s1, r_nz: rnz_s1};
		end
	end

	s2c_isqrt #(
		.WORD_BITS (W),
		.SIDE_BITS ($bits(geo_side_t))
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.src_vld  (vld_s2),
		.rad_a    (rc2_s2),
		.rad_b    (r2_s2),
		.side_in  (side_s2),
		.dst_vld  (sq_vld),
		.root_a   (rc_root),
		.root_b   (r_root),
		.side_out (sq_side)
	);

	always_comb begin
		dv_num[LANE_SIN_PHI] = sq_side.ay;
		dv_num[LANE_COS_PHI] = sq_side.ax;
		dv_num[LANE_SIN_TH] = rc_root;
		dv_num[LANE_COS_TH] = sq_side.az;
		dv_den[LANE_SIN_PHI] = rc_root;
		dv_den[LANE_COS_PHI] = rc_root;
		dv_den[LANE_SIN_TH] = r_root;
		dv_den[LANE_COS_TH] = r_root;
		dv_neg[LANE_SIN_PHI] = sq_side.sy;
		dv_neg[LANE_COS_PHI] = sq_side.sx;
		dv_neg[LANE_SIN_TH] = 1'b0;
		dv_neg[LANE_COS_TH] = sq_side.sz;
		dv_zero[LANE_SIN_PHI] = !sq_side.rc_nz;
		dv_zero[LANE_COS_PHI] = !sq_side.rc_nz;
		dv_zero[LANE_SIN_TH] = !sq_side.r_nz;
		dv_zero[LANE_COS_TH] = !sq_side.r_nz;
	end

	s2c_div #(
		.WORD_BITS (W),
		.FRAC_BITS (F),
		.SIDE_BITS ($bits(comp_t))
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.src_vld  (sq_vld),
		.num      (dv_num),
		.den      (dv_den),
		.neg      (dv_neg),
		.zero     (dv_zero),
		.side_in  (sq_side.comp),
		.dst_vld  (dv_vld),
		.trig     (dv_trig),
		.side_out (dv_comp)
	);

	s2c_rotate #(
		.WORD_BITS (W),
		.FRAC_BITS (F)
	) u_rotate (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.src_vld (dv_vld),
		.vr      (dv_comp.vr),
		.vt      (dv_comp.vt),
		.vp      (dv_comp.vp),
		.sp      (dv_trig[LANE_SIN_PHI]),
		.cp      (dv_trig[LANE_COS_PHI]),
		.st      (dv_trig[LANE_SIN_TH]),
		.ct      (dv_trig[LANE_COS_TH]),
		.psi_in  (dv_comp.psi),
		.dst_vld (rot_vld),
		.cx      (rot_x),
		.cy      (rot_y),
		.cz      (rot_z),
		.psi_out (rot_psi)
	);

	s2c_norm #(
		.WORD_BITS (W),
		.FRAC_BITS (F)
	) u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.src_vld (rot_vld),
		.cx_in   (rot_x),
		.cy_in   (rot_y),
		.cz_in   (rot_z),
		.psi     (rot_psi),
		.dst_vld (result_valid),
		.cx_out  (cart_x),
		.cy_out  (cart_y),
		.cz_out  (cart_z),
		.norm    (weighted_norm_sq)
	);

`ifndef SYNTHESIS
	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("input stalled without a held result transaction");
	a_zero_vector_zero_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && cart_x == '0 && cart_y == '0 && cart_z == '0)
			|-> weighted_norm_sq == '0)
		else $error("nonzero norm for a zero vector");
	a_held_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> result_valid)
		else $error("held result transaction lost");
`endif

endmodule

>>> verif/tb_spherical_to_cartesian_vector_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for spherical_to_cartesian_vector_core.
// Holds a directed table, random transactions and a fixed-point predictor of the transform.
// Depends on s2c_pkg and the core RTL.
module tb_spherical_to_cartesian_vector_core;
	import s2c_pkg::*;

	localparam int unsigned WB = WORD_BITS_DEF;
	localparam int unsigned FB = FRAC_BITS_DEF;
	localparam int unsigned NB = WB + FB;
	localparam int unsigned LATENCY = WB + FB + 13;
	localparam int unsigned N_RANDOM = 730;
	localparam int unsigned IDLE_LIMIT = 20000;
	localparam int unsigned HOLD_CYCLES = 200;
	localparam logic [WB-1:0] SMAX = {1'b0, {(WB-1){1'b1}}};
	localparam logic [WB-1:0] SMIN = {1'b1, {(WB-1){1'b0}}};
	localparam logic [WB-1:0] ONE = 1 << FB;

	typedef struct packed {
		logic [WB-1:0] vr, vt, vp, psi4, x, y, z;
	} point_t;

	typedef struct packed {
		logic [WB-1:0] cx, cy, cz;
		logic [NB-1:0] nsq;
	} cart_t;

	typedef struct {
		point_t p;
		logic known;
		cart_t c;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic signed [WB-1:0] comp_r = '0, comp_theta = '0, comp_phi = '0;
	logic [WB-1:0] conformal_factor = '0;
	logic signed [WB-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [WB-1:0] cart_x, cart_y, cart_z;
	logic [NB-1:0] weighted_norm_sq;

	cart_t expected_carts[$];
	row_t directed[$];
	int unsigned errors = 0;
	int unsigned n_sent = 0;
	int unsigned n_checked = 0;
	int unsigned idle_cycles = 0;
	int unsigned stall_left = 0;
	bit quiet_tail = 1'b0;
	bit hold_result = 1'b0;
	bit stimulus_done = 1'b0;

	spherical_to_cartesian_vector_core uut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint trig_ratio(input longint n, input logic [63:0] d);
		logic [63:0] q, m;
		m = (n < 0) ? -n : n;
		q = ((m << FB) + (d >> 1)) / d;
		return (n < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint fix_mul(input longint a, input longint b);
		logic [63:0] p, q, ma, mb;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		p = ma * mb;
		q = (p + (64'd1 << (FB - 1))) >> FB;
		return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [WB-1:0] clamp_word(input longint v);
		if (v > longint'(SMAX))
			return SMAX;
		if (v < -longint'(SMAX) - 1)
			return SMIN;
		return v[WB-1:0];
	endfunction

	function automatic cart_t transform_point(input point_t p);
		longint vr, vt, vp, x, y, z, sp, cp, st, ct, cx, cy, cz;
		logic [63:0] ax, ay, az, rc2, r2, rc;
		logic [127:0] s, prod;
		cart_t c;
		vr = longint'($signed(p.vr));
		vt = longint'($signed(p.vt));
		vp = longint'($signed(p.vp));
		x = longint'($signed(p.x));
		y = longint'($signed(p.y));
		z = longint'($signed(p.z));
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		az = (z < 0) ? -z : z;
		rc2 = ax * ax + ay * ay;
		r2 = rc2 + az * az;
		sp = 0; cp = 0; st = 0; ct = 0; rc = 0;
		if (rc2 > 0) begin
			rc = int_sqrt(rc2);
			sp = trig_ratio(y, rc);
			cp = trig_ratio(x, rc);
		end
		if (r2 > 0) begin
			st = trig_ratio(longint'(rc), int_sqrt(r2));
			ct = trig_ratio(z, int_sqrt(r2));
		end
		cx = fix_mul(fix_mul(vr, st), cp) + fix_mul(fix_mul(vt, ct), cp) - fix_mul(vp, sp);
		cy = fix_mul(fix_mul(vr, st), sp) + fix_mul(fix_mul(vt, ct), sp) + fix_mul(vp, cp);
		cz = fix_mul(vr, ct) - fix_mul(vt, st);
		c.cx = clamp_word(cx);
		c.cy = clamp_word(cy);
		c.cz = clamp_word(cz);
		cx = $signed(c.cx); cy = $signed(c.cy); cz = $signed(c.cz);
		s = 128'(cx * cx) + 128'(cy * cy) + 128'(cz * cz);
		prod = s * 128'(p.psi4);
		prod = (prod + (128'd1 << (2 * FB - 1))) >> (2 * FB);
		c.nsq = (prod >> NB != 0) ? {NB{1'b1}} : prod[NB-1:0];
		return c;
	endfunction

	function automatic logic [WB-1:0] rand_word();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 3) == 0 ? SMAX : SMIN;
			1: return WB'($signed($urandom_range(0, 8 * ONE)) - $signed(4 * ONE));
			2: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic point_t rand_point();
		point_t p;
		p.vr = rand_word(); p.vt = rand_word(); p.vp = rand_word();
		p.psi4 = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4 * ONE);
		p.x = rand_word(); p.y = rand_word(); p.z = rand_word();
		case ($urandom_range(0, 9))
			0: begin p.x = '0; p.y = '0; end
			1: begin p.x = '0; p.y = '0; p.z = '0; end
			default: ;
		endcase
		return p;
	endfunction

	task automatic add_row(input point_t p, input logic known, input cart_t c);
		row_t r;
		r.p = p; r.known = known; r.c = c;
		directed.push_back(r);
	endtask

	task automatic offer_point(input point_t p, input bit may_idle);
		int unsigned gap;
		if (may_idle && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 12);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		comp_r <= p.vr; comp_theta <= p.vt; comp_phi <= p.vp;
		conformal_factor <= p.psi4;
		pos_x <= p.x; pos_y <= p.y; pos_z <= p.z;
		do
			@(posedge clk);
		while (item_stall);
		n_sent++;
	endtask

	initial begin
		point_t p;
		cart_t zero_c, c;
		zero_c = '0;
		p = '{SMAX, SMIN, SMAX, '1, '0, '0, '0};
		add_row(p, 1'b1, zero_c);
		p = '{ONE, '0, '0, ONE, '0, '0, ONE};
		c = '{'0, '0, ONE, NB'(ONE)};
		add_row(p, 1'b1, c);
		p = '{ONE, '0, '0, ONE, '0, '0, SMIN};
		c = '{'0, '0, -ONE, NB'(ONE)};
		add_row(p, 1'b1, c);
		p = '{ONE, ONE, ONE, ONE, ONE, '0, '0};
		c = '{ONE, ONE, -ONE, NB'(3 * ONE)};
		add_row(p, 1'b1, c);
		p = '{SMAX, SMAX, SMAX, '1, SMAX, SMAX, SMAX};
		add_row(p, 1'b0, zero_c);
		p = '{SMIN, SMIN, SMIN, '1, SMIN, SMIN, SMIN};
		add_row(p, 1'b0, zero_c);
		p = '{SMIN, SMAX, SMIN, ONE, SMIN, SMAX, 1};
		add_row(p, 1'b0, zero_c);
		p = '{SMAX, '0, SMIN, '0, 1, 1, 1};
		add_row(p, 1'b0, zero_c);
		p = '{ONE, -ONE, 3 * ONE, 2 * ONE, '0, '0, -5};
		add_row(p, 1'b0, zero_c);
		p = '{'1, '1, '1, '1, '1, 1, '1};
		add_row(p, 1'b0, zero_c);
		p = '{-ONE, 2 * ONE, ONE, ONE, 3 * ONE, -4 * ONE, 12 * ONE};
		add_row(p, 1'b0, zero_c);
		p = '{'0, '0, '0, '1, SMAX, SMIN, '0};
		add_row(p, 1'b0, zero_c);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			expected_carts.push_back(directed[i].known ? directed[i].c
				: transform_point(directed[i].p));
			offer_point(directed[i].p, 1'b0);
		end
		for (int unsigned i = 0; i < N_RANDOM; i++) begin
			p = rand_point();
			if (i == N_RANDOM - 80)
				quiet_tail = 1'b1;
			expected_carts.push_back(transform_point(p));
			offer_point(p, !quiet_tail);
		end
		item_valid <= 1'b0;
		stimulus_done = 1'b1;
	end

	initial begin
		@(posedge arst_n);
		repeat (150) @(posedge clk);
		hold_result <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_result <= 1'b0;
	end

	always @(posedge clk) begin
		if (hold_result) begin
			result_stall <= 1'b1;
		end else if (quiet_tail) begin
			result_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (result_stall) begin
			result_stall <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			result_stall <= 1'b1;
			stall_left <= $urandom_range(0, 11);
		end
	end

	always @(posedge clk) begin
		cart_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_carts.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				want = expected_carts.pop_front();
				n_checked++;
				if (cart_x !== want.cx) begin
					$error("cart_x expected %h actual %h", want.cx, cart_x);
					errors++;
				end
				if (cart_y !== want.cy) begin
					$error("cart_y expected %h actual %h", want.cy, cart_y);
					errors++;
				end
				if (cart_z !== want.cz) begin
					$error("cart_z expected %h actual %h", want.cz, cart_z);
					errors++;
				end
				if (weighted_norm_sq !== want.nsq) begin
					$error("weighted_norm_sq expected %h actual %h", want.nsq,
						weighted_norm_sq);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Watchdog expired after %0d idle cycles.", idle_cycles);
			$display("tb_spherical_to_cartesian_vector_core: errors");
			$finish;
		end
	end

	initial begin
		wait (stimulus_done);
		while (expected_carts.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Sent %0d transactions (directed table plus random), checked %0d results.",
			n_sent, n_checked);
		if (errors == 0 && expected_carts.size() == 0)
			$display("tb_spherical_to_cartesian_vector_core: clean");
		else
			$display("tb_spherical_to_cartesian_vector_core: errors");
		$finish;
	end

endmodule
